[rtl/gef_pkg.sv]
package gef_pkg;

    localparam int ENV_BITS   = 24;
    localparam int COEFF_BITS = 25;
    localparam int DEPTH_BITS = 17;
    localparam int CFG_BITS   = 25;
    localparam int IDX_BITS   = 2;
    localparam int OPA_BITS   = 25;
    localparam int LVL_SHIFT  = 16;

    localparam logic [ENV_BITS-1:0]   ENV_ONE       = 24'd8388608;
    localparam logic [COEFF_BITS-1:0] ATTACK_RESET  = 25'd34916;
    localparam logic [COEFF_BITS-1:0] RELEASE_RESET = 25'd3495;
    localparam logic [CFG_BITS-1:0]   GATE_RESET    = '1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET   = 17'd65536;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_GATE    = 2'd2,
        CFG_DEPTH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_PREP = 6'b000100,
        S_MUL  = 6'b001000,
        S_ENV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

[rtl/gated_envelope_follower_core.sv]
// gated envelope follower
// input channel: one signed sample per beat on i_sample (i_valid / o_ready)
// output channel: one beat per input beat, o_level is the envelope times depth
// (q0.23, saturated at 1.0) and o_gate_open flags the attack branch
// (o_valid / i_ready)
// config port: i_cfg_we with i_cfg_index selects attack, release, gate level
// or depth; to be written only while no beat is in flight (not enforced)
// timing: each beat runs two products through one radix-4 shift-add unit,
// two multiplier bits per cycle over MUL_BITS multiplier bits, where
// MUL_BITS is the larger of 25 and COEFF_FRAC_BITS+1 rounded up to even;
// a new beat is taken only after the result of the last has left the unit
// o_ready is high only while the unit is free; the finished result sits in
// an output register, so a new beat is accepted while the receiver stalls;
// a second result waits in the unit until the register empties
// reset (synchronous, active low) clears the envelope, the handshake state
// and loads the default attack, release, gate level and depth
module gated_envelope_follower_core #(
    parameter int SAMPLE_BITS     = 24,
    parameter int COEFF_FRAC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [gef_pkg::ENV_BITS-1:0]        o_level,
    output logic                                o_gate_open,
    input  logic                                i_cfg_we,
    input  logic [gef_pkg::IDX_BITS-1:0]        i_cfg_index,
    input  logic [gef_pkg::CFG_BITS-1:0]        i_cfg_wdata
);

    import gef_pkg::*;

    localparam int MB_MIN = (COEFF_FRAC_BITS + 1 > COEFF_BITS) ? COEFF_FRAC_BITS + 1 : COEFF_BITS;
    localparam int MUL_BITS = MB_MIN + (MB_MIN % 2);
    localparam int STEPS = MUL_BITS / 2;
    localparam int CNT_BITS = $clog2(STEPS + 1);
    localparam int AW = OPA_BITS;
    localparam int PW = AW + MUL_BITS;
    localparam int QW = PW - COEFF_FRAC_BITS;
    localparam int LW = PW - LVL_SHIFT;
    localparam logic [MUL_BITS-1:0] COEFF_ONE = MUL_BITS'(1) << COEFF_FRAC_BITS;
    localparam logic [CNT_BITS-1:0] CNT_START = CNT_BITS'(STEPS);

    t_state r_state, n_state;

    logic [COEFF_BITS-1:0]    r_attack;
    logic [COEFF_BITS-1:0]    r_release;
    logic signed [CFG_BITS-1:0] r_gate;
    logic [DEPTH_BITS-1:0]    r_depth;

    logic [ENV_BITS-1:0]      r_env;
    logic [ENV_BITS-1:0]      r_mag;
    logic                     r_open;
    logic                     r_pass;

    logic signed [AW-1:0]     r_a;
    logic signed [AW+1:0]     r_a3;
    logic [MUL_BITS-1:0]      r_b;
    logic [PW-1:0]            r_acc;
    logic [CNT_BITS-1:0]      r_cnt;

    logic                     r_out_valid;
    logic [ENV_BITS-1:0]      r_out_level;
    logic                     r_out_gate;

    logic [SAMPLE_BITS-1:0]   w_abs;
    logic [ENV_BITS-1:0]      w_mag;
    logic                     w_open;
    logic                     w_in_beat;
    logic                     w_out_load;

    logic signed [AW+1:0]     w_a_ext;
    logic signed [AW+1:0]     w_addend;
    logic signed [AW+1:0]     w_hi_ext;
    logic signed [AW+1:0]     w_sum;

    logic signed [QW-1:0]     w_q;
    logic signed [QW:0]       w_env_sum;
    logic [ENV_BITS-1:0]      w_env_new;
    logic [LW-1:0]            w_lvl_full;
    logic [ENV_BITS-1:0]      w_lvl;

    // magnitude aligned to q0.23
    assign w_abs = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;

    generate
        if (SAMPLE_BITS > ENV_BITS) begin : g_trunc
            assign w_mag = w_abs[SAMPLE_BITS-1 -: ENV_BITS];
        end else if (SAMPLE_BITS == ENV_BITS) begin : g_same
            assign w_mag = w_abs;
        end else begin : g_pad
            assign w_mag = {w_abs, {(ENV_BITS-SAMPLE_BITS){1'b0}}};
        end
    endgenerate

    assign w_open = r_gate[CFG_BITS-1] | ({1'b0, w_mag} > $unsigned(r_gate));

    assign w_in_beat  = i_valid & o_ready;
    assign w_out_load = (r_state == S_DONE) & (~r_out_valid | i_ready);

    // radix-4 shift-add step
    assign w_a_ext  = {{2{r_a[AW-1]}}, r_a};
    assign w_hi_ext = {{2{r_acc[PW-1]}}, r_acc[PW-1:MUL_BITS]};

    always_comb begin
        unique case (r_b[1:0])
            2'd0:    w_addend = '0;
            2'd1:    w_addend = w_a_ext;
            2'd2:    w_addend = w_a_ext <<< 1;
            default: w_addend = r_a3;
        endcase
    end

    assign w_sum = w_hi_ext + w_addend;

    // floor shift, attack offset and clamp
    assign w_q = r_acc[PW-1:COEFF_FRAC_BITS];
    assign w_env_sum = {w_q[QW-1], w_q}
        + (r_open ? {{(QW+1-ENV_BITS){1'b0}}, r_env} : '0);

    always_comb begin
        priority if (w_env_sum[QW]) begin
            w_env_new = '0;
        end else if (w_env_sum > $signed({{(QW+1-ENV_BITS){1'b0}}, ENV_ONE})) begin
            w_env_new = ENV_ONE;
        end else begin
            w_env_new = w_env_sum[ENV_BITS-1:0];
        end
    end

    assign w_lvl_full = r_acc[PW-1:LVL_SHIFT];
    assign w_lvl = (w_lvl_full > {{(LW-ENV_BITS){1'b0}}, ENV_ONE}) ? ENV_ONE
                                                                 : w_lvl_full[ENV_BITS-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_LOAD;
            end
            S_LOAD: n_state = S_PREP;
            S_PREP: n_state = S_MUL;
            S_MUL: begin
                if (r_cnt == CNT_BITS'(1)) n_state = r_pass ? S_DONE : S_ENV;
            end
            S_ENV: n_state = S_PREP;
            S_DONE: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_env       <= '0;
            r_out_valid <= 1'b0;
            r_attack    <= ATTACK_RESET;
            r_release   <= RELEASE_RESET;
            r_gate      <= GATE_RESET;
            r_depth     <= DEPTH_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_ATTACK:  r_attack  <= i_cfg_wdata[COEFF_BITS-1:0];
                    CFG_RELEASE: r_release <= i_cfg_wdata[COEFF_BITS-1:0];
                    CFG_GATE:    r_gate    <= i_cfg_wdata;
                    CFG_DEPTH:   r_depth   <= i_cfg_wdata[DEPTH_BITS-1:0];
                endcase
            end
            if (r_state == S_ENV) r_env <= w_env_new;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_mag  <= w_mag;
            r_open <= w_open;
        end
        unique case (r_state)
            S_LOAD: begin
                r_pass <= 1'b0;
                if (r_open) begin
                    r_a <= $signed({1'b0, r_mag}) - $signed({1'b0, r_env});
                    r_b <= {{(MUL_BITS-COEFF_BITS){1'b0}}, r_attack};
                end else begin
                    r_a <= $signed({1'b0, r_env});
                    if ({{(MUL_BITS-COEFF_BITS){1'b0}}, r_release} >= COEFF_ONE) begin
                        r_b <= '0;
                    end else begin
                        r_b <= COEFF_ONE - {{(MUL_BITS-COEFF_BITS){1'b0}}, r_release};
                    end
                end
            end
            S_PREP: begin
                r_acc <= '0;
                r_a3  <= w_a_ext + (w_a_ext <<< 1);
                r_cnt <= CNT_START;
            end
            S_MUL: begin
                r_acc <= {w_sum, r_acc[MUL_BITS-1:2]};
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt - CNT_BITS'(1);
            end
            S_ENV: begin
                r_pass <= 1'b1;
                r_a    <= $signed({1'b0, w_env_new});
                r_b    <= {{(MUL_BITS-DEPTH_BITS){1'b0}}, r_depth};
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_level <= w_lvl;
            r_out_gate  <= r_open;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_level     = r_out_level;
    assign o_gate_open = r_out_gate;

endmodule

[tb/gated_envelope_follower_core_tb.sv]
module gated_envelope_follower_core_tb;
    import gef_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int ONE_Q24     = 1 << 24;

    localparam logic signed [23:0] CORNER_SAMPLES [8] = '{
        24'sd0, 24'sd1, -24'sd1, 24'sd8388607, -24'sd8388608, -24'sd8388607,
        24'sd4194304, -24'sd4194304
    };

    typedef struct packed {
        logic [ENV_BITS-1:0] level;
        logic                gate_open;
    } t_follower_out;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic                    o_ready;
    logic signed [23:0]      i_sample    = '0;
    logic                    o_valid;
    logic                    i_ready     = 1'b0;
    logic [ENV_BITS-1:0]     o_level;
    logic                    o_gate_open;
    logic                    i_cfg_we    = 1'b0;
    logic [IDX_BITS-1:0]     i_cfg_index = CFG_ATTACK;
    logic [CFG_BITS-1:0]     i_cfg_wdata = '0;

    logic [COEFF_BITS-1:0]   attack_cfg  = ATTACK_RESET;
    logic [COEFF_BITS-1:0]   release_cfg = RELEASE_RESET;
    logic signed [CFG_BITS-1:0] gate_cfg = GATE_RESET;
    logic [DEPTH_BITS-1:0]   depth_cfg   = DEPTH_RESET;
    longint                  envelope_model = 0;

    logic signed [23:0]      sample_queue [$];
    t_follower_out           level_expect [$];
    bit                      calm        = 1'b0;
    int                      error_count = 0;
    int                      idle_cycles = 0;

    gated_envelope_follower_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_level     (o_level),
        .o_gate_open (o_gate_open),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void follow_sample(input logic signed [23:0] s);
        longint        mag;
        longint        env;
        longint        lvl;
        t_follower_out res;
        mag = (s < 0) ? -longint'(s) : longint'(s);
        env = envelope_model;
        res.gate_open = (mag > longint'(gate_cfg));
        if (res.gate_open) begin
            env = env + (((mag - env) * longint'(attack_cfg)) >>> 24);
        end else if (longint'(release_cfg) >= ONE_Q24) begin
            env = 0;
        end else begin
            env = (env * (ONE_Q24 - longint'(release_cfg))) >>> 24;
        end
        if (env < 0) env = 0;
        if (env > longint'(ENV_ONE)) env = longint'(ENV_ONE);
        envelope_model = env;
        lvl = (env * longint'(depth_cfg)) >>> LVL_SHIFT;
        if (lvl > longint'(ENV_ONE)) lvl = longint'(ENV_ONE);
        res.level = lvl[ENV_BITS-1:0];
        level_expect.push_back(res);
    endfunction

    function automatic logic signed [23:0] with_sign(input int mag, input bit neg);
        if (mag < 0) mag = 0;
        if (mag > 8388608) mag = 8388608;
        if (neg) return 24'(-longint'(mag));
        return (mag > 8388607) ? 24'sd8388607 : 24'(mag);
    endfunction

    // input beats
    always @(posedge i_clk) begin : drive_samples
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) follow_sample(i_sample);
            if (!i_valid || o_ready) begin
                if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
                    i_valid  <= 1'b1;
                    i_sample <= sample_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result beats
    always @(posedge i_clk) begin : check_levels
        t_follower_out want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (level_expect.size() == 0) begin
                    $error("unexpected result beat: level %0d gate_open %0b",
                           o_level, o_gate_open);
                    error_count++;
                end else begin
                    want = level_expect.pop_front();
                    if (o_level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, o_level);
                        error_count++;
                    end
                    if (o_gate_open !== want.gate_open) begin
                        $error("gate_open: expected %0b, got %0b",
                               want.gate_open, o_gate_open);
                        error_count++;
                    end
                end
            end
            i_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("gated_envelope_follower_core_tb: done, errors");
        $finish;
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_ATTACK:  attack_cfg  = data;
            CFG_RELEASE: release_cfg = data;
            CFG_GATE:    gate_cfg    = data;
            CFG_DEPTH:   depth_cfg   = data[DEPTH_BITS-1:0];
            default:     ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (sample_queue.size() != 0 || i_valid || level_expect.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic queue_random(input int count);
        int left;
        int amp;
        int len;
        int kind;
        int mag;
        left = count;
        while (left > 0) begin
            kind = $urandom_range(9);
            if (kind <= 5) begin
                // loud burst then near silence
                amp = $urandom_range(0, 8388608);
                len = $urandom_range(4, 40);
                for (int j = 0; j < len && left > 0; j++) begin
                    mag = amp - int'($urandom_range(0, amp / 16));
                    sample_queue.push_back(with_sign(mag, 1'($urandom_range(1))));
                    left--;
                end
                len = $urandom_range(4, 40);
                for (int j = 0; j < len && left > 0; j++) begin
                    sample_queue.push_back(with_sign($urandom_range(0, 255),
                                                     1'($urandom_range(1))));
                    left--;
                end
            end else if (kind <= 7) begin
                sample_queue.push_back(24'($urandom));
                left--;
            end else if (kind == 8) begin
                sample_queue.push_back(CORNER_SAMPLES[$urandom_range(7)]);
                left--;
            end else begin
                // magnitudes right around the gate level, when it lies in the sample range
                if (gate_cfg >= 0 && gate_cfg <= 8388608)
                    mag = int'(gate_cfg) + int'($urandom_range(0, 4)) - 2;
                else
                    mag = $urandom_range(0, 8388608);
                sample_queue.push_back(with_sign(mag, 1'($urandom_range(1))));
                left--;
            end
        end
    endtask

    task automatic run_phase(input logic [COEFF_BITS-1:0] atk,
                             input logic [COEFF_BITS-1:0] rel,
                             input logic [CFG_BITS-1:0]   gate,
                             input logic [DEPTH_BITS-1:0] dep,
                             input int                    count);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_GATE, gate);
        write_reg(CFG_DEPTH, CFG_BITS'(dep));
        queue_random(count / 2);
        drain();
        queue_random(count - count / 2);
        drain();
    endtask

    initial begin : stimulus
        logic [COEFF_BITS-1:0] atk;
        logic [COEFF_BITS-1:0] rel;
        logic [CFG_BITS-1:0]   gate;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: gate below zero opens on every sample
        foreach (CORNER_SAMPLES[i]) sample_queue.push_back(CORNER_SAMPLES[i]);
        repeat (3) sample_queue.push_back(24'sd8388607);
        repeat (3) sample_queue.push_back(24'sd0);
        repeat (3) sample_queue.push_back(-24'sd8388608);
        repeat (3) sample_queue.push_back(24'sd0);
        drain();
        queue_random(100);
        drain();

        run_phase(25'd16777216, 25'd0, 25'd0, 17'd65536, 150);
        run_phase('1, 25'd16777216, 25'd4194304, '1, 150);
        run_phase(25'd0, '1, 25'd16777215, 17'd0, 100);
        calm = 1'b1;
        run_phase(25'd8388608, 25'd4096, 25'h1000000, 17'd32768, 150);
        calm = 1'b0;
        run_phase(25'd8388608, 25'd65536, 25'd8388607, 17'd65536, 100);

        repeat (4) begin
            atk = $urandom_range(1) ? 25'($urandom_range(1, 1 << 22)) : 25'($urandom);
            rel = $urandom_range(1) ? 25'($urandom_range(1, 1 << 20)) : 25'($urandom);
            case ($urandom_range(2))
                0:       gate = 25'($urandom_range(0, 8388608));
                1:       gate = 25'($urandom);
                default: gate = 25'(-int'($urandom_range(1, 16777216)));
            endcase
            run_phase(atk, rel, gate, 17'($urandom_range(0, 131071)), 120);
        end

        repeat (40) @(posedge i_clk);
        if (level_expect.size() != 0) begin
            $error("%0d result beats never arrived", level_expect.size());
            error_count++;
        end
        if (error_count == 0)
            $display("gated_envelope_follower_core_tb: done, clean");
        else
            $display("gated_envelope_follower_core_tb: done, errors");
        $finish;
    end

endmodule
